// ----- hdl/bfa_pkg.sv -----
// Shared types, codes and widths for the best-fit block allocator.
package bfa_pkg;

  // Fixed field widths of the stream items
  localparam int KIND_W      = 2;
  localparam int INDEX_W     = 4;
  localparam int FIELD_W     = 16;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 24;
  localparam int COUNT_W     = 5;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

  // Defaults for the top-level parameters
  localparam int MAX_BLOCKS_DEF = 16;
  localparam int SIZE_WIDTH_DEF = 16;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // latch the incoming request and reset the search
    logic load_wr;   // write the loaded size into the table
    logic item_rd;   // read the addressed entry
    logic scan_run;  // advance the search by one entry
    logic wb;        // write back the chosen entry
    logic out_load;  // move the result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

// ----- hdl/best_fit_block_allocator_core.sv -----
// Best-fit block allocator: top level joining the sequencer and the datapath.
// Path from acceptance to the output register: a load or read passes its own state
//   and ST_DONE; an allocate scans block_count entries (capped at MAX_BLOCKS), then ST_WB and ST_DONE.
// Throughput: one request at a time; the next request is taken the cycle after the
//   result is registered, even while that result still waits on m_tready.
// Reset (rst, synchronous): all free sizes read as zero, block_count returns to 16,
//   the output register empties and the input side is ready.
module best_fit_block_allocator_core #(
  parameter int MAX_BLOCKS = bfa_pkg::MAX_BLOCKS_DEF,
  parameter int SIZE_WIDTH = bfa_pkg::SIZE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration: block_count, number of blocks searched by an allocate
  input  logic                            cfg_wr_en,
  input  logic [bfa_pkg::COUNT_W-1:0]     cfg_wr_data,
  // Request stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [bfa_pkg::IN_DATA_W-1:0]   s_tdata,   // [3:0] block_index, [19:4] size_value
  input  logic [bfa_pkg::KIND_W-1:0]      s_tuser,   // [1:0] kind
  // Result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [bfa_pkg::OUT_DATA_W-1:0]  m_tdata,   // [3:0] chosen_block, [19:4] remaining_size
  output logic                            m_tuser    // [0] granted
);

  bfa_pkg::cmd_t    cmd;
  bfa_pkg::status_t status;

  // Sequencer: one request from acceptance to output register, then back to idle.
  // An allocate walks the table one entry per cycle, each entry compared in the
  // cycle after its registered read is issued.
  bfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: size table with per-entry valid bits (unwritten entries read as
  // zero), running best candidate, write-back of the chosen entry and the
  // output register that holds a result until it is taken.
  bfa_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule

// ----- hdl/bfa_ctrl.sv -----
// Request sequencer of the best-fit block allocator.
module bfa_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic [bfa_pkg::KIND_W-1:0] s_tuser,
  output logic                       s_tready,
  input  bfa_pkg::status_t           status,
  output bfa_pkg::cmd_t              cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_READ,
    ST_SCAN,
    ST_WB,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          case (s_tuser)
            bfa_pkg::KIND_LOAD:  state_next = ST_LOAD;
            bfa_pkg::KIND_READ:  state_next = ST_READ;
            bfa_pkg::KIND_ALLOC: state_next = ST_SCAN;
            default:             state_next = ST_DONE;
          endcase
        end
      end
      ST_LOAD: begin
        cmd.load_wr = 1'b1;
        state_next  = ST_DONE;
      end
      ST_READ: begin
        cmd.item_rd = 1'b1;
        state_next  = ST_DONE;
      end
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (status.scan_done) begin
          state_next = ST_WB;
        end
      end
      ST_WB: begin
        cmd.wb     = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hdl/bfa_datapath.sv -----
// Size table, search registers and output register of the best-fit allocator.
module bfa_datapath #(
  parameter int MAX_BLOCKS = bfa_pkg::MAX_BLOCKS_DEF,
  parameter int SIZE_WIDTH = bfa_pkg::SIZE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  bfa_pkg::cmd_t                   cmd,
  output bfa_pkg::status_t                status,
  input  logic                            cfg_wr_en,
  input  logic [bfa_pkg::COUNT_W-1:0]     cfg_wr_data,
  input  logic [bfa_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic [bfa_pkg::KIND_W-1:0]      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [bfa_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                            m_tuser
);

  // Only indices 0..15 can ever be loaded; entries above stay zero for good.
  localparam int ENTRY_COUNT = (MAX_BLOCKS < 16) ? MAX_BLOCKS : 16;
  localparam int AW          = $clog2(ENTRY_COUNT);
  localparam int LIMIT_MAX   = (MAX_BLOCKS < 31) ? MAX_BLOCKS : 31;
  localparam int CW          = $clog2(LIMIT_MAX + 1);
  localparam int IW          = bfa_pkg::INDEX_W;
  localparam int FW          = bfa_pkg::FIELD_W;

  // Table
  logic [SIZE_WIDTH-1:0] mem [ENTRY_COUNT];
  logic [ENTRY_COUNT-1:0] valid;
  logic [SIZE_WIDTH-1:0] rd_q;
  logic                  rd_vq;
  logic [SIZE_WIDTH-1:0] entry_val;

  // Configuration
  logic [bfa_pkg::COUNT_W-1:0] block_count;

  // Request
  logic [bfa_pkg::KIND_W-1:0] item_kind;
  logic [IW-1:0]              item_idx;
  logic [SIZE_WIDTH-1:0]      item_size;
  logic                       item_in_range;

  // Search
  logic [CW-1:0]         scan_cnt;
  logic [CW-1:0]         scan_limit;
  logic                  pend;
  logic [CW-1:0]         pend_idx;
  logic                  pend_oob;
  logic                  found;
  logic [CW-1:0]         best_idx;
  logic [SIZE_WIDTH-1:0] best_val;
  logic [SIZE_WIDTH-1:0] cand;
  logic                  cand_better;
  logic [SIZE_WIDTH-1:0] best_rem;

  // Ports of the table
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [SIZE_WIDTH-1:0] wr_data;
  logic                  scan_issue;

  // Result
  logic          res_granted;
  logic [IW-1:0] res_block;
  logic [FW-1:0] res_rem;

  always_comb begin
    if (32'(block_count) < LIMIT_MAX) begin
      scan_limit = CW'(block_count);
    end else begin
      scan_limit = CW'(LIMIT_MAX);
    end
  end

  assign item_in_range = 32'(item_idx) < MAX_BLOCKS;
  assign entry_val     = rd_vq ? rd_q : '0;
  assign scan_issue    = cmd.scan_run && (scan_cnt != scan_limit);

  assign cand        = pend_oob ? '0 : entry_val;
  assign cand_better = pend && (cand >= item_size) && (!found || (cand < best_val));
  assign best_rem    = best_val - item_size;

  assign status.scan_done = (scan_cnt == scan_limit) && !pend;
  assign status.out_free  = !m_tvalid || m_tready;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = item_idx[AW-1:0];
    if (cmd.item_rd) begin
      rd_en = 1'b1;
    end else if (scan_issue) begin
      rd_en   = 1'b1;
      rd_addr = scan_cnt[AW-1:0];
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = item_idx[AW-1:0];
    wr_data = item_size;
    if (cmd.load_wr) begin
      wr_en = item_in_range;
    end else if (cmd.wb) begin
      wr_en   = found && (best_idx < CW'(ENTRY_COUNT));
      wr_addr = best_idx[AW-1:0];
      wr_data = best_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q  <= mem[rd_addr];
      rd_vq <= valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= bfa_pkg::COUNT_RESET;
    end else if (cfg_wr_en) begin
      block_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_kind <= s_tuser;
      item_idx  <= s_tdata[IW-1:0];
      item_size <= SIZE_WIDTH'(s_tdata[IW +: FW]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
      pend     <= 1'b0;
      found    <= 1'b0;
    end else if (cmd.accept) begin
      scan_cnt <= '0;
      pend     <= 1'b0;
      found    <= 1'b0;
    end else if (cmd.scan_run) begin
      pend <= scan_issue;
      if (scan_issue) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
      if (cand_better) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_issue) begin
      pend_idx <= scan_cnt;
      pend_oob <= scan_cnt >= CW'(ENTRY_COUNT);
    end
    if (cmd.scan_run && cand_better) begin
      best_idx <= pend_idx;
      best_val <= cand;
    end
  end

  always_comb begin
    res_granted = 1'b0;
    res_block   = '0;
    res_rem     = '0;
    case (item_kind)
      bfa_pkg::KIND_LOAD: begin
        res_granted = 1'b1;
        res_block   = item_idx;
        res_rem     = item_in_range ? FW'(item_size) : '0;
      end
      bfa_pkg::KIND_READ: begin
        res_granted = 1'b1;
        res_block   = item_idx;
        res_rem     = item_in_range ? FW'(entry_val) : '0;
      end
      bfa_pkg::KIND_ALLOC: begin
        if (found) begin
          res_granted = 1'b1;
          res_block   = IW'(best_idx);
          res_rem     = FW'(best_rem);
        end
      end
      default: begin
        res_granted = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tuser <= res_granted;
      m_tdata <= {(bfa_pkg::OUT_DATA_W - IW - FW)'(0), res_rem, res_block};
    end
  end

endmodule

// ----- hdl/bfa_checker.sv -----
// Port-level checks for the best-fit block allocator, bound to the top level.
module bfa_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [bfa_pkg::OUT_DATA_W-1:0]  m_tdata,
  input logic                            m_tuser
);

  // Leave reset empty and ready for a request
  a_reset_state: assert property (@(posedge clk) rst |=> (!m_tvalid && s_tready))
    else $error("output not empty or input not ready after reset");

  // A request occupies the block: no second request on the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted on back-to-back cycles");

  // A refused or unknown request carries no block and no size
  a_denied_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("denied result carries data");

  // Hold a stalled result
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind best_fit_block_allocator_core bfa_checker u_bfa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
